// ===== hw/rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB pixel converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // Field widths
   localparam int HUE_W  = 15;
   localparam int FRAC_W = 9;
   localparam int CHAN_W = 8;

   // Derived widths
   localparam int PROD_W = 2 * FRAC_W;   // v*s
   localparam int REM_W  = 13;           // hue mod 7680
   localparam int WGT_W  = 12;           // 0..3840
   localparam int DIFF_W = 20;           // signed 256v - p
   localparam int TERM_W = 30;           // p*3840 and p*f
   localparam int NUM_W  = 32;           // signed channel numerator
   localparam int SCL_W  = 36;           // 17 * numerator

   // Hue geometry, 1/64 degree units
   localparam logic [HUE_W-1:0] HUE_SPAN = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_PAIR = 15'd7680;

   // 255 / (65536 * 3840) reduces to 17 / 2^24
   localparam logic [SCL_W-1:0] SCL_MUL   = 36'd17;
   localparam int               SCL_SHIFT = 24;

   // 60-degree sector
   typedef enum logic [2:0] {
      SECT_RY,   // C on red,   X on green
      SECT_YG,   // X on red,   C on green
      SECT_GC,   // C on green, X on blue
      SECT_CB,   // X on green, C on blue
      SECT_BM,   // X on red,   C on blue
      SECT_MR    // C on red,   X on blue
   } sector_type;

   typedef logic signed [NUM_W-1:0] num_type;

   // Stage 1 payload
   typedef struct packed {
      logic [PROD_W-1:0] prod;    // v*s, scale 2^-16
      logic [FRAC_W-1:0] value;
      logic [WGT_W-1:0]  weight;  // X weight f, scale 1/3840
      sector_type        sector;
   } front_type;

   // Stage 2 payload
   typedef struct packed {
      num_type           base;    // 3840*(256v - p)
      logic [TERM_W-1:0] term_c;  // p*3840
      logic [TERM_W-1:0] term_x;  // p*f
      sector_type        sector;
   } prod_type;

   // Stage 3 payload
   typedef struct packed {
      num_type num_r;
      num_type num_g;
      num_type num_b;
   } place_type;

   // Stage 4 payload
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

endpackage

// ===== hw/rtl/hsvrgb_front.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_front
// Stage 1: v*s product, hue folding into X weight, and sector decode.
// ----------------------------------------------------------------------------
module hsvrgb_front import hsvrgb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [HUE_W-1:0]  in_hue,
   input  logic [FRAC_W-1:0] in_saturation,
   input  logic [FRAC_W-1:0] in_value,
   output logic              out_valid,
   input  logic              out_ready,
   output front_type         out_data
);

   logic             vld_ff;
   front_type        data_ff;
   front_type        data_in;
   logic [REM_W-1:0] rem;
   logic [REM_W-1:0] fold_dist;

   // Hue mod 7680 by compare and subtract against the multiples
   always_comb begin
      if (in_hue >= 15'(4 * HUE_PAIR)) begin
         rem = REM_W'(in_hue - 15'(4 * HUE_PAIR));
      end else if (in_hue >= 15'(3 * HUE_PAIR)) begin
         rem = REM_W'(in_hue - 15'(3 * HUE_PAIR));
      end else if (in_hue >= 15'(2 * HUE_PAIR)) begin
         rem = REM_W'(in_hue - 15'(2 * HUE_PAIR));
      end else if (in_hue >= HUE_PAIR) begin
         rem = REM_W'(in_hue - HUE_PAIR);
      end else begin
         rem = REM_W'(in_hue);
      end
   end

   // Distance from mid-pair, then weight f = 3840 - d
   always_comb begin
      if (rem >= REM_W'(HUE_SPAN)) begin
         fold_dist = rem - REM_W'(HUE_SPAN);
      end else begin
         fold_dist = REM_W'(HUE_SPAN) - rem;
      end
   end

   // Next stage contents
   always_comb begin
      data_in.prod   = PROD_W'(in_value) * PROD_W'(in_saturation);
      data_in.value  = in_value;
      data_in.weight = WGT_W'(REM_W'(HUE_SPAN) - fold_dist);
      if (in_hue < HUE_SPAN) begin
         data_in.sector = SECT_RY;
      end else if (in_hue < 15'(2 * HUE_SPAN)) begin
         data_in.sector = SECT_YG;
      end else if (in_hue < 15'(3 * HUE_SPAN)) begin
         data_in.sector = SECT_GC;
      end else if (in_hue < 15'(4 * HUE_SPAN)) begin
         data_in.sector = SECT_CB;
      end else if (in_hue < 15'(5 * HUE_SPAN)) begin
         data_in.sector = SECT_BM;
      end else begin
         data_in.sector = SECT_MR;
      end
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/hsvrgb_prod.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_prod
// Stage 2: offset numerator 3840*(256v - p), chroma term p*3840, X term p*f.
// ----------------------------------------------------------------------------
module hsvrgb_prod import hsvrgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output prod_type  out_data
);

   logic                     vld_ff;
   prod_type                 data_ff;
   prod_type                 data_in;
   logic signed [DIFF_W-1:0] diff;

   // 256v - p, may go negative when saturation exceeds one
   assign diff = $signed({3'b000, in_data.value, 8'h00}) - $signed({2'b00, in_data.prod});

   always_comb begin
      data_in.base   = NUM_W'(diff) * $signed(NUM_W'(HUE_SPAN));
      data_in.term_c = TERM_W'(in_data.prod) * TERM_W'(HUE_SPAN);
      data_in.term_x = TERM_W'(in_data.prod) * TERM_W'(in_data.weight);
      data_in.sector = in_data.sector;
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/hsvrgb_place.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_place
// Stage 3: place C, X and 0 on the channels by sector and add the offset.
// ----------------------------------------------------------------------------
module hsvrgb_place import hsvrgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  prod_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output place_type out_data
);

   logic      vld_ff;
   place_type data_ff;
   place_type data_in;
   num_type   c_num;
   num_type   x_num;
   num_type   m_num;

   assign c_num = $signed({2'b00, in_data.term_c});
   assign x_num = $signed({2'b00, in_data.term_x});
   assign m_num = in_data.base;

   // Sector placement
   always_comb begin
      case (in_data.sector)
         SECT_RY: begin
            data_in.num_r = m_num + c_num;
            data_in.num_g = m_num + x_num;
            data_in.num_b = m_num;
         end
         SECT_YG: begin
            data_in.num_r = m_num + x_num;
            data_in.num_g = m_num + c_num;
            data_in.num_b = m_num;
         end
         SECT_GC: begin
            data_in.num_r = m_num;
            data_in.num_g = m_num + c_num;
            data_in.num_b = m_num + x_num;
         end
         SECT_CB: begin
            data_in.num_r = m_num;
            data_in.num_g = m_num + x_num;
            data_in.num_b = m_num + c_num;
         end
         SECT_BM: begin
            data_in.num_r = m_num + x_num;
            data_in.num_g = m_num;
            data_in.num_b = m_num + c_num;
         end
         default: begin
            data_in.num_r = m_num + c_num;
            data_in.num_g = m_num;
            data_in.num_b = m_num + x_num;
         end
      endcase
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Stage 4: floor(255*n / (65536*3840)) as (17*n) >> 24, clamp to 0..255.
// ----------------------------------------------------------------------------
module hsvrgb_scale import hsvrgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  place_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rgb_type   out_data
);

   logic    vld_ff;
   rgb_type data_ff;
   rgb_type data_in;

   function automatic logic [CHAN_W-1:0] chan_scale(input num_type num);
      logic [SCL_W-1:0] scaled;
      scaled = {5'b00000, num[NUM_W-2:0]} * SCL_MUL;
      if (num[NUM_W-1]) begin
         chan_scale = '0;
      end else if (scaled[SCL_W-1:SCL_SHIFT+CHAN_W] != '0) begin
         chan_scale = '1;
      end else begin
         chan_scale = scaled[SCL_SHIFT+CHAN_W-1:SCL_SHIFT];
      end
   endfunction

   always_comb begin
      data_in.red   = chan_scale(in_data.num_r);
      data_in.green = chan_scale(in_data.num_g);
      data_in.blue  = chan_scale(in_data.num_b);
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/hsv_to_rgb_convert_top.sv =====
// An accepted req transaction passes the front, prod, place and scale registers in order
// before it is offered as its rsp transaction.
// Throughput: one pixel per cycle while rsp_tready is high; the four register stages each hold one pixel.
// Per-stage valid bits let bubbles collapse while rsp_tready is low.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_top
// HSV to 8-bit RGB pixel converter, four-stage streaming pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_top import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // hue[14:0], saturation[23:15], value[32:24], zero[39:33]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   logic      s1_valid, s1_ready;
   logic      s2_valid, s2_ready;
   logic      s3_valid, s3_ready;
   front_type s1_data;
   prod_type  s2_data;
   place_type s3_data;
   rgb_type   s4_data;

   // Product, hue fold, sector
   hsvrgb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_hue        (req_tdata[14:0]),
      .in_saturation (req_tdata[23:15]),
      .in_value      (req_tdata[32:24]),
      .out_valid     (s1_valid),
      .out_ready     (s1_ready),
      .out_data      (s1_data)
   );

   // Chroma, X and offset numerators
   hsvrgb_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // Sector placement
   hsvrgb_place u_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // Scale and clamp, output register
   hsvrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (s4_data)
   );

   assign rsp_tdata = s4_data;

endmodule

// ===== hw/rtl/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks on the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped under stall");

   // Stalled result payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed under stall");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // With rsp_tready held high, an accepted transaction emerges on rsp_tvalid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

   // Zero brightness gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[32:24] == 9'd0)
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tdata == 24'd0)
      else $error("zero value did not give black");

endmodule

bind hsv_to_rgb_convert_top hsvrgb_checker u_hsvrgb_checker (.*);
